[rtl/jtsm_pkg.sv]
// Package for the JTAG TAP shift master.
// Holds the command codes and the item and result structs shared by the engine
// and the top level. It depends on nothing else.
package jtsm_pkg;

  typedef enum logic [1:0] {
    ACT_GO_IDLE  = 2'd0,
    ACT_SHIFT_IR = 2'd1,
    ACT_SHIFT_DR = 2'd2,
    ACT_TICK     = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] shift_bits;
    logic [4:0]  bit_count;
    logic        stay_in_update;
    logic        tdo;
  } item_t;

  typedef struct packed {
    logic        pulse;
    logic        tms;
    logic        tdi;
    logic [15:0] captured;
    logic        done_res;
    logic        rejected;
  } result_t;

endpackage

[rtl/jtsm_engine.sv]
// TAP walking engine: the operation state registers and the single-pass
// next-state and result logic for one item. Depends on jtsm_pkg.
module jtsm_engine #(
  parameter int IR_LENGTH   = 4,
  parameter int MAX_DR_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  jtsm_pkg::item_t  item,
  output logic             has_result,
  output jtsm_pkg::result_t result
);
  import jtsm_pkg::*;

  localparam int SHW = (IR_LENGTH > MAX_DR_BITS) ? IR_LENGTH : MAX_DR_BITS;
  localparam int BLW = $clog2(SHW + 1);
  localparam int PHW = $clog2(SHW + 5);
  localparam int IXW = $clog2(SHW);
  localparam logic [SHW-1:0] IR_MASK = SHW'((64'd1 << IR_LENGTH) - 64'd1);

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_IDLE = 2'd1,
    OP_IR   = 2'd2,
    OP_DR   = 2'd3
  } op_t;

  op_t            op_kind, op_kind_next;
  logic [PHW-1:0] step_phase, step_phase_next;
  logic [SHW-1:0] out_shift, out_shift_next;
  logic [SHW-1:0] in_shift, in_shift_next;
  logic [BLW-1:0] bits_left, bits_left_next;
  logic           end_in_update, end_in_update_next;
  logic           update_given, update_given_next;
  logic           tms_level, tms_level_next;
  logic           tdi_level, tdi_level_next;

  logic [SHW+15:0] bits_wide;
  logic [SHW+15:0] cap_wide;
  logic [5:0]      count_sat;
  logic [SHW:0]    dr_mask;
  logic [PHW-1:0]  pre_len;
  logic [PHW-1:0]  ones_len;
  logic [PHW-1:0]  idx_full;
  logic [IXW-1:0]  idx;
  logic            done;

  always_comb begin
    bits_wide = {{SHW{1'b0}}, item.shift_bits};
    count_sat = {1'b0, item.bit_count};
    if (count_sat == 6'd0) begin
      count_sat = 6'd1;
    end
    if (count_sat > 6'(MAX_DR_BITS)) begin
      count_sat = 6'(MAX_DR_BITS);
    end
    dr_mask  = ({{SHW{1'b0}}, 1'b1} << count_sat) - {{SHW{1'b0}}, 1'b1};
    pre_len  = (op_kind == OP_IR) ? PHW'(4) : PHW'(3);
    ones_len = (op_kind == OP_IR) ? PHW'(2) : PHW'(1);
    idx_full = step_phase - pre_len;
    idx      = idx_full[IXW-1:0];
  end

  always_comb begin
    op_kind_next       = op_kind;
    step_phase_next    = step_phase;
    out_shift_next     = out_shift;
    in_shift_next      = in_shift;
    bits_left_next     = bits_left;
    end_in_update_next = end_in_update;
    update_given_next  = update_given;
    tms_level_next     = tms_level;
    tdi_level_next     = tdi_level;
    has_result         = 1'b0;
    done               = 1'b0;
    result.pulse       = 1'b0;
    result.rejected    = 1'b0;

    if (item.action != ACT_TICK) begin
      if (op_kind != OP_NONE) begin
        has_result      = 1'b1;
        result.rejected = 1'b1;
      end else begin
        step_phase_next    = '0;
        in_shift_next      = '0;
        update_given_next  = 1'b0;
        end_in_update_next = item.stay_in_update;
        unique case (item.action)
          ACT_GO_IDLE: begin
            op_kind_next   = OP_IDLE;
            out_shift_next = '0;
            bits_left_next = '0;
          end
          ACT_SHIFT_IR: begin
            op_kind_next   = OP_IR;
            bits_left_next = BLW'(IR_LENGTH);
            out_shift_next = bits_wide[SHW-1:0] & IR_MASK;
          end
          default: begin
            op_kind_next   = OP_DR;
            bits_left_next = BLW'(count_sat);
            out_shift_next = bits_wide[SHW-1:0] & dr_mask[SHW-1:0];
          end
        endcase
      end
    end else if (op_kind != OP_NONE) begin
      has_result   = 1'b1;
      result.pulse = 1'b1;
      if (op_kind == OP_IDLE) begin
        tms_level_next  = (step_phase < PHW'(5));
        step_phase_next = step_phase + PHW'(1);
        if (step_phase >= PHW'(5)) begin
          done         = 1'b1;
          op_kind_next = OP_NONE;
        end
      end else if (step_phase < pre_len) begin
        tms_level_next  = (step_phase < ones_len);
        step_phase_next = step_phase + PHW'(1);
      end else if (bits_left != '0) begin
        tdi_level_next     = out_shift[0];
        tms_level_next     = (bits_left == BLW'(1));
        in_shift_next[idx] = in_shift[idx] | item.tdo;
        out_shift_next     = out_shift >> 1;
        bits_left_next     = bits_left - BLW'(1);
        step_phase_next    = step_phase + PHW'(1);
      end else if (!update_given) begin
        tms_level_next    = 1'b1;
        update_given_next = 1'b1;
        if (end_in_update) begin
          done         = 1'b1;
          op_kind_next = OP_NONE;
        end
      end else begin
        tms_level_next = 1'b0;
        done           = 1'b1;
        op_kind_next   = OP_NONE;
      end
    end

    cap_wide        = {16'b0, in_shift_next};
    result.tms      = tms_level_next;
    result.tdi      = tdi_level_next;
    result.captured = cap_wide[15:0];
    result.done_res = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_kind       <= OP_NONE;
      step_phase    <= '0;
      out_shift     <= '0;
      in_shift      <= '0;
      bits_left     <= '0;
      end_in_update <= 1'b0;
      update_given  <= 1'b0;
      tms_level     <= 1'b1;
      tdi_level     <= 1'b0;
    end else if (advance) begin
      op_kind       <= op_kind_next;
      step_phase    <= step_phase_next;
      out_shift     <= out_shift_next;
      in_shift      <= in_shift_next;
      bits_left     <= bits_left_next;
      end_in_update <= end_in_update_next;
      update_given  <= update_given_next;
      tms_level     <= tms_level_next;
      tdi_level     <= tdi_level_next;
    end
  end

endmodule

[rtl/jtag_tap_shift_master.sv]
// An item transferred on the input passes the input register and then the result register
// before its result, if any, shows on the outputs.
// Throughput: one item per cycle, sustained while the result side keeps taking transfers;
// the limit is the operation state update in the engine.
// Reset (synchronous, active high) empties both registers and puts the engine
// in its no-operation state with TMS held high and TDI held low.
//
// Top level of the JTAG TAP shift master. Depends on jtsm_pkg and jtsm_engine.
module jtag_tap_shift_master #(
  parameter int IR_LENGTH   = 4,
  parameter int MAX_DR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] shift_bits,
  input  logic [4:0]  bit_count,
  input  logic        stay_in_update,
  input  logic        tdo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pulse,
  output logic        tms,
  output logic        tdi,
  output logic [15:0] captured,
  output logic        done_res,
  output logic        rejected
);
  import jtsm_pkg::*;

  // Input register: holds one accepted command or tick until the engine takes it.
  logic    stage_valid;
  item_t   stage_item;

  // Result register: holds the finished result until the downstream side takes it.
  logic    res_valid;
  result_t res_data;

  logic    advance;
  logic    eng_has_result;
  result_t eng_result;

  // The engine consumes the staged item whenever the result register is free,
  // or will be freed by a transfer at this same edge. Items that produce no
  // result (a command while idle, a tick while idle) simply leave the result
  // register empty.
  assign advance  = stage_valid && (!res_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_item.action         <= action_t'(action);
      stage_item.shift_bits     <= shift_bits;
      stage_item.bit_count      <= bit_count;
      stage_item.stay_in_update <= stay_in_update;
      stage_item.tdo            <= tdo;
    end
  end

  jtsm_engine #(
    .IR_LENGTH  (IR_LENGTH),
    .MAX_DR_BITS(MAX_DR_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (stage_item),
    .has_result(eng_has_result),
    .result    (eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= eng_has_result;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
    if (advance && eng_has_result) begin
      res_data <= eng_result;
    end
  end

  assign out_valid = res_valid;
  assign pulse     = res_data.pulse;
  assign tms       = res_data.tms;
  assign tdi       = res_data.tdi;
  assign captured  = res_data.captured;
  assign done_res  = res_data.done_res;
  assign rejected  = res_data.rejected;

`ifndef SYNTHESIS
  // A result produced by the engine must show up in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && eng_has_result |=> res_valid)
    else $error("engine result was not registered");

  // With the result register empty the input side can never be blocked.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A rejected command never drives a TCK pulse or ends an operation.
  a_reject_no_pulse: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.rejected |-> !res_data.pulse && !res_data.done_res)
    else $error("rejected result carries a pulse");

  // The end of an operation always comes with a TCK pulse.
  a_done_has_pulse: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> res_data.pulse)
    else $error("done without a pulse");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the JTAG TAP shift master (jtag_tap_shift_master).
// A directed table and then random TAP operations go in, and every result is compared with
// a cycle-free model of the TAP walk that lives in this file. Depends on jtsm_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jtsm_pkg::*;

  localparam int IR_LEN      = 4;
  localparam int DR_MAX      = 16;
  localparam int N_ITEMS     = 1700;
  localparam int HOLD_AT     = 600;   // item count at which the long result stall starts
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE_AT    = 1100;  // item count at which the sender drains the block
  localparam int CALM_FROM   = N_ITEMS - 250;
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 100;

  // Kind of TAP operation that the model has armed.
  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_RESET_IDLE = 2'd1,
    OP_IR         = 2'd2,
    OP_DR         = 2'd3
  } tap_op_t;

  // One row of the directed table. When fixed is set, the row carries its own expected
  // outcome (has_res and res); otherwise the TAP model decides.
  typedef struct packed {
    item_t   it;
    logic    fixed;
    logic    has_res;
    result_t res;
  } dir_row_t;

  localparam result_t NO_RES    = '0;
  // Pulses of the go-to-idle walk right after reset: TMS high, TDI still at its reset level.
  localparam result_t IDLE_HI   = '{1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0};
  localparam result_t IDLE_DONE = '{1'b1, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0};
  // A command during that walk: no pulse, the held pin levels, and the reject flag.
  localparam result_t BUSY_REJ  = '{1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1};

  localparam int DIR_N = 26;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // A tick with nothing armed gives no pulse at all.
    '{'{ACT_TICK,     16'hFFFF, 5'd31, 1'b1, 1'b1}, 1'b1, 1'b0, NO_RES},
    // Go to idle from reset; stay_in_update must make no difference.
    '{'{ACT_GO_IDLE,  16'hFFFF, 5'd31, 1'b1, 1'b1}, 1'b1, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b1, 1'b1, IDLE_HI},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b1, 1'b1, IDLE_HI},
    // A command in the middle of the walk is turned away.
    '{'{ACT_SHIFT_DR, 16'hFFFF, 5'd16, 1'b1, 1'b1}, 1'b1, 1'b1, BUSY_REJ},
    '{'{ACT_TICK,     16'hFFFF, 5'd31, 1'b1, 1'b1}, 1'b1, 1'b1, IDLE_HI},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b1, 1'b1, IDLE_HI},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b1, 1'b1, IDLE_HI},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b1, 1'b1, IDLE_DONE},
    // Instruction of all ones, stopping in Update-IR.
    '{'{ACT_SHIFT_IR, 16'hFFFF, 5'd0,  1'b1, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    // Data register of length zero, which counts as one bit, started from Update.
    '{'{ACT_SHIFT_DR, 16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b1}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES},
    '{'{ACT_TICK,     16'h0000, 5'd0,  1'b0, 1'b0}, 1'b0, 1'b0, NO_RES}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [15:0] shift_bits = '0;
  logic [4:0]  bit_count = '0;
  logic        stay_in_update = 1'b0;
  logic        tdo = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        pulse;
  logic        tms;
  logic        tdi;
  logic [15:0] captured;
  logic        done_res;
  logic        rejected;

  // Model of the TAP walk, starting from the reset state.
  tap_op_t     tap_op     = OP_NONE;
  logic [5:0]  tap_step   = '0;
  logic [31:0] tx_bits    = '0;
  logic [31:0] rx_bits    = '0;
  logic [4:0]  tx_left    = '0;
  logic        stop_upd   = 1'b0;
  logic        tms_q      = 1'b1;
  logic        tdi_q      = 1'b0;
  logic        upd_done   = 1'b0;

  result_t     tap_results_due [$];
  int          n_taken  = 0;
  int          n_err    = 0;
  bit          hold_req = 1'b0;
  bit          calm     = 1'b0;

  always #5 clk = ~clk;

  jtag_tap_shift_master #(
    .IR_LENGTH   (IR_LEN),
    .MAX_DR_BITS (DR_MAX)
  ) i_dut (.*);

  // Advances the TAP model by one accepted item and says which result, if any, it causes.
  task automatic tap_walk(input item_t it, output bit has, output result_t r);
    int unsigned n, pre, ones;
    has = 1'b0;
    r   = '0;
    if (it.action != ACT_TICK) begin
      if (tap_op != OP_NONE) begin
        // Only one operation at a time; the command is dropped and flagged.
        has        = 1'b1;
        r.rejected = 1'b1;
      end else begin
        tap_step = '0;
        rx_bits  = '0;
        upd_done = 1'b0;
        stop_upd = it.stay_in_update;
        case (it.action)
          ACT_GO_IDLE: begin
            tap_op  = OP_RESET_IDLE;
            tx_bits = '0;
            tx_left = '0;
          end
          ACT_SHIFT_IR: begin
            tap_op  = OP_IR;
            tx_left = 5'(IR_LEN);
            tx_bits = 32'(it.shift_bits) & ((32'd1 << IR_LEN) - 32'd1);
          end
          default: begin
            // Zero length counts as one bit; lengths past the register size saturate.
            n = 32'(it.bit_count);
            if (n == 0) n = 1;
            if (n > DR_MAX) n = DR_MAX;
            tap_op  = OP_DR;
            tx_left = 5'(n);
            tx_bits = 32'(it.shift_bits) & ((32'd1 << n) - 32'd1);
          end
        endcase
      end
    end else if (tap_op != OP_NONE) begin
      has     = 1'b1;
      r.pulse = 1'b1;
      if (tap_op == OP_RESET_IDLE) begin
        // Five pulses with TMS high reach Test-Logic-Reset from anywhere, one low goes idle.
        tms_q    = (tap_step < 5);
        tap_step = tap_step + 6'd1;
        if (tap_step >= 6) begin
          r.done_res = 1'b1;
          tap_op     = OP_NONE;
        end
      end else begin
        // Select-DR/IR, Capture, then Shift: the IR walk goes through one more Select state.
        pre  = (tap_op == OP_IR) ? 4 : 3;
        ones = (tap_op == OP_IR) ? 2 : 1;
        if (tap_step < pre) begin
          tms_q    = (tap_step < ones);
          tap_step = tap_step + 6'd1;
        end else if (tx_left > 0) begin
          tdi_q    = tx_bits[0];
          tms_q    = (tx_left == 1);
          rx_bits  = rx_bits | (32'(it.tdo) << ((tap_step - pre) & 31));
          tx_bits  = tx_bits >> 1;
          tx_left  = tx_left - 5'd1;
          tap_step = tap_step + 6'd1;
        end else if (!upd_done) begin
          // Exit1 to Update, which may be the end of the operation.
          tms_q    = 1'b1;
          upd_done = 1'b1;
          if (stop_upd) begin
            r.done_res = 1'b1;
            tap_op     = OP_NONE;
          end
        end else begin
          tms_q      = 1'b0;
          r.done_res = 1'b1;
          tap_op     = OP_NONE;
        end
      end
    end
    r.tms      = tms_q;
    r.tdi      = tdi_q;
    r.captured = rx_bits[15:0];
  endtask

  // Random payload for one item of the given kind. Lengths lean toward the special ones.
  function automatic item_t rand_item(action_t a);
    item_t it;
    it.action         = a;
    it.shift_bits     = 16'($urandom);
    it.stay_in_update = 1'($urandom);
    it.tdo            = 1'($urandom);
    case ($urandom_range(0, 7))
      0:       it.bit_count = 5'd0;
      1:       it.bit_count = 5'd16;
      2:       it.bit_count = 5'($urandom_range(17, 31));
      default: it.bit_count = 5'($urandom_range(1, 16));
    endcase
    return it;
  endfunction

  // Offers one item on the input channel, from a falling edge, and holds it until the
  // transfer happens. On the transfer the TAP model runs and the expectation is queued.
  // A fixed row queues its own outcome; the model still runs to keep its state in step.
  task automatic send(input item_t it, input bit fixed = 1'b0, input bit fixed_has = 1'b0,
                      input result_t fixed_res = '0);
    bit      has;
    bit      ignored;
    result_t r;
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid       = 1'b1;
    action         = it.action;
    shift_bits     = it.shift_bits;
    bit_count      = it.bit_count;
    stay_in_update = it.stay_in_update;
    tdo            = it.tdo;
    do @(posedge clk); while (!in_ready);
    ignored = (it.action == ACT_TICK) && (tap_op == OP_NONE);
    tap_walk(it, has, r);
    if (fixed) begin
      if (fixed_has) tap_results_due.push_back(fixed_res);
    end else if (has) begin
      tap_results_due.push_back(r);
    end
    if (!ignored) n_taken++;
    if (n_taken == HOLD_AT) hold_req = 1'b1;
    if (n_taken >= CALM_FROM) calm = 1'b1;
    @(negedge clk);
  endtask

  function automatic void chk(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      if (n_err < MAX_REPORTS)
        $error("%s mismatch: expected %0h, got %0h", fname, want, got);
      n_err++;
    end
  endfunction

  // Result side: every transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (tap_results_due.size() == 0) begin
        if (n_err < MAX_REPORTS)
          $error("result transfer with nothing expected (pulse %0b, rejected %0b)",
                 pulse, rejected);
        n_err++;
      end else begin
        want = tap_results_due.pop_front();
        chk("pulse",    16'(want.pulse),    16'(pulse));
        chk("tms",      16'(want.tms),      16'(tms));
        chk("tdi",      16'(want.tdi),      16'(tdi));
        chk("captured", want.captured,      captured);
        chk("done_res", 16'(want.done_res), 16'(done_res));
        chk("rejected", 16'(want.rejected), 16'(rejected));
      end
    end
  end

  // Result-side back-pressure. Short random stalls, plus one long stall that lets the
  // block fill up and push back on the input while the sender keeps offering items.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Stimulus, drain and verdict.
  initial begin
    int k;
    int w;
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_TAB[i])
      send(DIR_TAB[i].it, DIR_TAB[i].fixed, DIR_TAB[i].has_res, DIR_TAB[i].res);

    // Mostly complete operations with random content; now and then a command lands in
    // the middle of one and gets rejected, or a tick arrives with nothing armed.
    while (n_taken < N_ITEMS) begin
      k = $urandom_range(0, 9);
      send(rand_item(k < 2 ? ACT_GO_IDLE : (k < 5 ? ACT_SHIFT_IR : ACT_SHIFT_DR)));
      while (tap_op != OP_NONE) begin
        if ($urandom_range(0, 24) == 0)
          send(rand_item(action_t'($urandom_range(0, 2))));
        else
          send(rand_item(ACT_TICK));
      end
      if ($urandom_range(0, 5) == 0) send(rand_item(ACT_TICK));
      // Once, the sender goes quiet until every outstanding result has come back.
      if (!paused && n_taken >= PAUSE_AT) begin
        paused   = 1'b1;
        in_valid = 1'b0;
        while (tap_results_due.size() != 0) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    for (w = 0; w < DRAIN_LIMIT && tap_results_due.size() != 0; w++) @(negedge clk);
    if (tap_results_due.size() != 0) begin
      $error("%0d expected results never arrived", tap_results_due.size());
      n_err++;
    end
    // Two-stage pipeline: an extra wait catches any stray result.
    repeat (10) @(negedge clk);
    if (n_err == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Hard stop, several times the slowest correct run.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
